// ----- rtl/serial_command_stopwatch_core_assert.svh -----
// Assertion macros for the serial command stopwatch checker.
// Expects clk and rst to be visible where a macro is used.
`ifndef SERIAL_COMMAND_STOPWATCH_CORE_ASSERT_SVH
`define SERIAL_COMMAND_STOPWATCH_CORE_ASSERT_SVH

// Same-cycle implication, skipped while reset is high
`define SCSW_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, skipped while reset is high
`define SCSW_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

// Same-cycle implication, checked across reset as well
`define SCSW_ASSERT_ALWAYS(name, pre, post, msg) \
  name: assert property (@(posedge clk) (pre) |-> (post)) \
    else $error(msg);

`endif

// ----- rtl/scsw_pkg.sv -----
// Shared types, constants and reply text for the serial command stopwatch.
// No dependencies; imported by every module of the block.
`default_nettype none

package scsw_pkg;

  // Width of the wrapping seconds count
  localparam int SECONDS_WIDTH = 16;
  localparam int SEC_CNT_W     = $clog2(SECONDS_WIDTH);

  localparam int PREFIX_DEPTH = 5;
  localparam int POS_W        = 3;
  localparam int TICK_W       = 16;
  localparam logic [TICK_W-1:0] TPS_RESET = 16'd1000;

  // Command queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Input operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] DIGIT_BASE = 8'h30;

  // Reply lengths and character index width
  localparam int STOP_LEN  = 10;
  localparam int SHORT_LEN = 6;
  localparam int IDX_W     = 4;
  localparam int DIGITS    = 4;

  localparam logic [7:0] WORD_STOP  [0:3] = '{8'h53, 8'h54, 8'h4F, 8'h50};
  localparam logic [7:0] WORD_START [0:4] = '{8'h53, 8'h54, 8'h41, 8'h52, 8'h54};
  localparam logic [7:0] TAIL_STOP  [0:5] = '{8'h20, 8'h43, 8'h45, 8'h4B, 8'h2E, 8'h0A};
  localparam logic [7:0] REPLY_START[0:5] = '{8'h53, 8'h54, 8'h41, 8'h52, 8'h54, 8'h0A};
  localparam logic [7:0] REPLY_ERROR[0:5] = '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52, 8'h0A};

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_STOP,
    CMD_START,
    CMD_ERROR
  } cmd_kind_t;

  // One classified command request, queued for the back end
  typedef struct packed {
    cmd_kind_t                 kind;
    logic [SECONDS_WIDTH-1:0]  seconds;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONVERT,
    BK_SEND
  } back_state_t;

  // Length of the reply for a command kind
  function automatic logic [IDX_W-1:0] reply_len(input cmd_kind_t kind);
    reply_len = (kind == CMD_STOP) ? IDX_W'(STOP_LEN) : IDX_W'(SHORT_LEN);
  endfunction

  // Character at position idx of the reply; digits holds four BCD digits
  function automatic logic [7:0] reply_char(input cmd_kind_t kind,
                                            input logic [IDX_W-1:0] idx,
                                            input logic [4*DIGITS-1:0] digits);
    logic [IDX_W-1:0] tail_idx;
    logic [3:0]       digit;
    tail_idx = idx - IDX_W'(DIGITS);
    digit    = digits[4*(DIGITS-1) +: 4];
    reply_char = 8'h00;
    unique case (kind)
      CMD_STOP: begin
        if (idx < IDX_W'(DIGITS)) begin
          unique case (idx[1:0])
            2'd0: digit = digits[15:12];
            2'd1: digit = digits[11:8];
            2'd2: digit = digits[7:4];
            2'd3: digit = digits[3:0];
          endcase
          reply_char = DIGIT_BASE + {4'h0, digit};
        end else if (idx < IDX_W'(STOP_LEN)) begin
          reply_char = TAIL_STOP[tail_idx[2:0]];
        end
      end
      CMD_START: begin
        if (idx < IDX_W'(SHORT_LEN)) reply_char = REPLY_START[idx[2:0]];
      end
      default: begin
        if (idx < IDX_W'(SHORT_LEN)) reply_char = REPLY_ERROR[idx[2:0]];
      end
    endcase
  endfunction

  // One double-dabble step on four BCD digits, shifting in one binary bit
  function automatic logic [4*DIGITS-1:0] dabble(input logic [4*DIGITS-1:0] bcd,
                                                 input logic bit_in);
    logic [4*DIGITS-1:0] adj;
    adj = bcd;
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
    end
    dabble = {adj[4*DIGITS-2:0], bit_in};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/serial_command_stopwatch_core.sv -----
// Serial command stopwatch. Input requests are either a received byte or a
// millisecond tick; both are taken one per cycle while the two-entry command
// queue has room, so in_stall rises only when two replies wait in the queue
// behind the one being converted or sent. Ticks and non-terminating bytes
// produce nothing. A carriage return queues one reply, which passes from the
// queue through the back end's pickup in idle and then through the output
// register. Characters of "START\n" or "ERROR\n" follow at one per cycle
// while out_stall is low. A STOP reply first passes through the serial
// binary-to-decimal converter, which takes in the seconds count bit by bit,
// MSB first; its ten characters then follow at one per cycle while out_stall
// is low. Between replies the back end returns to idle for the next pickup.
// last marks the final character. ticks_per_second is written through
// cfg_write/cfg_data and takes effect on the next tick.
// Depends on scsw_pkg, scsw_front, scsw_fifo and scsw_back.
`default_nettype none

module serial_command_stopwatch_core (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_write,
  input  wire [15:0]          cfg_data,
  input  wire                 in_valid,
  output logic                in_stall,
  input  scsw_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  wire                 out_stall,
  output scsw_pkg::out_item_t out_item
);
  import scsw_pkg::*;

  logic push;
  cmd_t push_data;
  logic full;
  logic pop;
  logic not_empty;
  cmd_t head;

  scsw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  scsw_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  scsw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_ready (not_empty),
    .cmd       (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ----- rtl/scsw_front.sv -----
// Front end: takes input requests, runs the tick and seconds counters,
// stores the command text and classifies it on carriage return. Uses scsw_pkg.
`default_nettype none

module scsw_front (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     cfg_write,
  input  wire [15:0]              cfg_data,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  scsw_pkg::in_item_t      in_item,
  output logic                    push,
  output scsw_pkg::cmd_t          push_data,
  input  wire                     full
);
  import scsw_pkg::*;

  logic [TICK_W-1:0]        ticks_per_second;
  logic [TICK_W-1:0]        tick_count;
  logic [TICK_W-1:0]        tick_next;
  logic [SECONDS_WIDTH-1:0] seconds;
  logic [7:0]               prefix [0:PREFIX_DEPTH-1];
  logic [POS_W-1:0]         wr_pos;
  logic                     accept;
  logic                     is_cr;
  logic                     stop_hit;
  logic                     start_hit;

  assign in_stall  = full;
  assign accept    = in_valid && !full;
  assign is_cr     = (in_item.rx_byte == CHAR_CR);
  assign tick_next = tick_count + TICK_W'(1);

  // Prefix compare against both keywords
  always_comb begin
    stop_hit  = 1'b1;
    start_hit = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (prefix[i] != WORD_STOP[i]) stop_hit = 1'b0;
    end
    for (int i = 0; i < PREFIX_DEPTH; i++) begin
      if (prefix[i] != WORD_START[i]) start_hit = 1'b0;
    end
  end

  // Command request toward the queue
  assign push = accept && (in_item.operation == OP_BYTE) && is_cr;
  always_comb begin
    push_data.seconds = seconds;
    if (stop_hit)       push_data.kind = CMD_STOP;
    else if (start_hit) push_data.kind = CMD_START;
    else                push_data.kind = CMD_ERROR;
  end

  // Counters, register and text store
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TPS_RESET;
      tick_count       <= '0;
      seconds          <= '0;
      wr_pos           <= '0;
      for (int i = 0; i < PREFIX_DEPTH; i++) prefix[i] <= 8'h00;
    end else begin
      if (cfg_write) ticks_per_second <= cfg_data;
      if (accept) begin
        if (in_item.operation == OP_TICK) begin
          if (tick_next >= ticks_per_second) begin
            tick_count <= '0;
            seconds    <= seconds + SECONDS_WIDTH'(1);
          end else begin
            tick_count <= tick_next;
          end
        end else if (!is_cr) begin
          if (wr_pos < POS_W'(PREFIX_DEPTH)) begin
            prefix[wr_pos] <= in_item.rx_byte;
            wr_pos         <= wr_pos + POS_W'(1);
          end
        end else begin
          // End of command: clear the store, START also clears seconds
          wr_pos <= '0;
          for (int i = 0; i < PREFIX_DEPTH; i++) prefix[i] <= 8'h00;
          if (!stop_hit && start_hit) seconds <= '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/scsw_fifo.sv -----
// Short command queue between the front and back ends.
// Holds classified command requests; uses scsw_pkg.
`default_nettype none

module scsw_fifo (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  input  scsw_pkg::cmd_t  push_data,
  output logic            full,
  input  wire             pop,
  output logic            not_empty,
  output scsw_pkg::cmd_t  head
);
  import scsw_pkg::*;

  cmd_t                  entries [0:FIFO_DEPTH-1];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign full      = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + FIFO_CNT_W'(1);
      else if (do_pop && !do_push) count <= count - FIFO_CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/scsw_back.sv -----
// Back end: pops command requests, converts seconds to four decimal digits bit
// by bit for STOP and streams the reply through an output register. Uses scsw_pkg.
`default_nettype none

module scsw_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cmd_ready,
  input  scsw_pkg::cmd_t      cmd,
  output logic                pop,
  output logic                out_valid,
  input  wire                 out_stall,
  output scsw_pkg::out_item_t out_item
);
  import scsw_pkg::*;

  back_state_t              state, state_next;
  cmd_kind_t                kind, kind_next;
  logic [SECONDS_WIDTH-1:0] bin, bin_next;
  logic [4*DIGITS-1:0]      bcd, bcd_next;
  logic [SEC_CNT_W-1:0]     cnt, cnt_next;
  logic [IDX_W-1:0]         idx, idx_next;
  logic                     valid_next;
  out_item_t                item_next;
  logic                     out_load;
  logic                     is_last;

  assign out_load = (state == BK_SEND) && (!out_valid || !out_stall);
  assign is_last  = (idx == reply_len(kind) - IDX_W'(1));

  // State register and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= valid_next;
    end
    kind     <= kind_next;
    bin      <= bin_next;
    bcd      <= bcd_next;
    cnt      <= cnt_next;
    idx      <= idx_next;
    out_item <= item_next;
  end

  // Next state and outputs
  always_comb begin
    state_next = state;
    kind_next  = kind;
    bin_next   = bin;
    bcd_next   = bcd;
    cnt_next   = cnt;
    idx_next   = idx;
    pop        = 1'b0;
    item_next  = out_item;
    valid_next = out_valid && out_stall;
    unique case (state)
      BK_IDLE: begin
        if (cmd_ready) begin
          pop       = 1'b1;
          kind_next = cmd.kind;
          bin_next  = cmd.seconds;
          bcd_next  = '0;
          cnt_next  = '0;
          idx_next  = '0;
          state_next = (cmd.kind == CMD_STOP) ? BK_CONVERT : BK_SEND;
        end
      end
      BK_CONVERT: begin
        // One seconds bit per cycle, MSB first; top digit carry drops (mod 10000)
        bcd_next = dabble(bcd, bin[SECONDS_WIDTH-1]);
        bin_next = {bin[SECONDS_WIDTH-2:0], 1'b0};
        cnt_next = cnt + SEC_CNT_W'(1);
        if (cnt == SEC_CNT_W'(SECONDS_WIDTH - 1)) state_next = BK_SEND;
      end
      BK_SEND: begin
        if (out_load) begin
          item_next.tx_byte = reply_char(kind, idx, bcd);
          item_next.last    = is_last;
          valid_next        = 1'b1;
          idx_next          = idx + IDX_W'(1);
          if (is_last) state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/scsw_checker.sv -----
// Port-level checker for the serial command stopwatch, bound to the top level.
// Uses scsw_pkg and the macros in serial_command_stopwatch_core_assert.svh.
`default_nettype none
`include "serial_command_stopwatch_core_assert.svh"

module scsw_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 in_stall,
  input wire                 out_valid,
  input wire                 out_stall,
  input scsw_pkg::out_item_t out_item
);
  import scsw_pkg::*;

  // A stalled result keeps its valid and its payload
  `SCSW_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(out_item), "stalled result changed")
  // Every reply character is printable text or newline, never zero
  `SCSW_ASSERT_NOW(a_char_nonzero, out_valid, out_item.tx_byte != 8'h00, "zero reply character")
  // The queue is not full and no result is valid when reset is released
  `SCSW_ASSERT_ALWAYS(a_reset_stall, !rst && $past(rst), !in_stall && !out_valid, "busy out of reset")

endmodule

bind serial_command_stopwatch_core scsw_checker u_scsw_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Testbench for serial_command_stopwatch_core: sends byte and tick requests,
// predicts every reply character in-line and checks each one as it leaves.
// Depends on scsw_pkg and the serial_command_stopwatch_core RTL.

module tb;
  import scsw_pkg::*;

  localparam int IDLE_LIMIT   = 5000;  // cycles with no handshake before giving up
  localparam int SETTLE_TICKS = 40;    // covers the seconds converter plus a reply

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      cfg_write = 1'b0;
  logic [15:0] cfg_data = '0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  serial_command_stopwatch_core DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stopwatch state as the block should hold it
  logic [7:0]  cmd_text [PREFIX_DEPTH];
  int unsigned text_len;
  logic [15:0] tick_cnt;
  logic [15:0] sec_cnt;
  logic [15:0] tick_period;
  out_item_t   reply_q [$];

  int errors       = 0;
  int req_count    = 0;
  int chars_seen   = 0;
  int stop_replies = 0;
  int period_writes = 0;
  int src_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_req     = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got 0x%0h expected 0x%0h at t=%0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void queue_char(input logic [7:0] ch, input logic fin);
    out_item_t r;
    r.tx_byte = ch;
    r.last    = fin;
    reply_q.push_back(r);
  endfunction

  function automatic void queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i], i == s.len() - 1);
  endfunction

  function automatic bit text_begins(input string w);
    for (int i = 0; i < w.len(); i++)
      if (cmd_text[i] != w[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Advance the stopwatch by one accepted request and queue its reply characters
  function automatic void predict_reply(input in_item_t it);
    logic [15:0] nxt;
    int unsigned v;
    if (it.operation == OP_TICK) begin
      nxt = tick_cnt + 16'd1;
      if (nxt >= tick_period) begin
        tick_cnt = '0;
        sec_cnt  = sec_cnt + 16'd1;
      end else begin
        tick_cnt = nxt;
      end
    end else if (it.rx_byte != CHAR_CR) begin
      // only the first five characters are kept
      if (text_len < PREFIX_DEPTH) begin
        cmd_text[text_len] = it.rx_byte;
        text_len++;
      end
    end else begin
      if (text_begins("STOP")) begin
        v = sec_cnt % 10000;
        queue_char(8'h30 + 8'(v / 1000), 1'b0);
        queue_char(8'h30 + 8'((v / 100) % 10), 1'b0);
        queue_char(8'h30 + 8'((v / 10) % 10), 1'b0);
        queue_char(8'h30 + 8'(v % 10), 1'b0);
        queue_text(" CEK.\n");
        stop_replies++;
      end else if (text_begins("START")) begin
        queue_text("START\n");
        sec_cnt = '0;
      end else begin
        queue_text("ERROR\n");
      end
      foreach (cmd_text[i]) cmd_text[i] = 8'h00;
      text_len = 0;
    end
  endfunction

  // Receiver: random stall, optional long hold-off, and the reply checker
  int hold_left = 0;
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      chars_seen++;
      if (reply_q.size() == 0) begin
        report_mismatch("unexpected character", out_item.tx_byte, 0);
      end else begin
        want = reply_q.pop_front();
        if (out_item.tx_byte !== want.tx_byte)
          report_mismatch("tx_byte", out_item.tx_byte, want.tx_byte);
        if (out_item.last !== want.last)
          report_mismatch("last", out_item.last, want.last);
      end
    end
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Watchdog: counts cycles with no handshake on either side
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d replies pending",
                 IDLE_LIMIT, reply_q.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // Offer one request, with random sender gaps; valid stays high on return
  task automatic send_req(input logic op, input logic [7:0] b);
    in_item_t it;
    it.operation = op;
    it.rx_byte   = b;
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_reply(it);
    req_count++;
  endtask

  task automatic send_tick();
    send_req(OP_TICK, 8'($urandom_range(255)));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_req(OP_BYTE, s[i]);
  endtask

  // Text followed by a carriage return
  task automatic send_line(input string s);
    send_text(s);
    send_req(OP_BYTE, CHAR_CR);
  endtask

  // Sender waits until every reply is back and the block has settled
  task automatic drain_replies();
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Period register write; only called with the block idle
  task automatic write_period(input logic [15:0] v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    tick_period = v;
    period_writes++;
  endtask

  task automatic test_commands();
    // default period; seconds still zero
    send_text("STOP");
    send_req(OP_BYTE, CHAR_CR);
    // overlong START: sixth character dropped
    send_text("STARTZ");
    send_req(OP_BYTE, CHAR_CR);
    // tick carrying a full byte is still just a tick
    send_req(OP_TICK, 8'hFF);
    send_req(OP_TICK, 8'h00);
    // stored zero byte and all-ones byte never match
    send_req(OP_BYTE, 8'h00);
    send_req(OP_BYTE, 8'hFF);
    send_req(OP_BYTE, CHAR_CR);
    // short START stays an error, empty line too
    send_text("STAR");
    send_req(OP_BYTE, CHAR_CR);
    send_req(OP_BYTE, CHAR_CR);
    drain_replies();
  endtask

  task automatic test_period_extremes();
    // zero period: every tick is a full second
    write_period(16'd0);
    send_line("START");
    repeat (3) send_tick();
    send_line("STOP");
    drain_replies();
    write_period(16'd1);
    repeat (7) send_tick();
    send_line("STOPP");
    drain_replies();
    write_period(16'hFFFF);
    send_line("START");
    repeat (5) send_tick();
    send_line("STOP");
    drain_replies();
    // period lowered under the running tick count: next tick ends the second
    write_period(16'd50);
    send_line("START");
    repeat (30) send_tick();
    drain_replies();
    write_period(16'd10);
    send_tick();
    send_line("STOP");
    drain_replies();
  endtask

  task automatic test_multi_digit();
    // two-digit readout with carries through the converter
    write_period(16'd0);
    send_line("START");
    repeat (47) send_tick();
    send_line("STOP");
    drain_replies();
  endtask

  task automatic maybe_ticks();
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 6)) send_tick();
  endtask

  // Mostly well-formed commands with ticks mixed in; some junk and corruption
  task automatic send_random_command();
    logic [7:0] txt [$];
    string w;
    int kind;
    kind = $urandom_range(9);
    w = (kind <= 3 || kind == 8 && $urandom_range(1)) ? "STOP" : "START";
    if (kind <= 6 || kind == 8)
      for (int i = 0; i < w.len(); i++) txt.push_back(w[i]);
    if (kind == 8) txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
    if (kind == 7) repeat ($urandom_range(1, 7)) txt.push_back(8'($urandom_range(255)));
    if (kind <= 6 && $urandom_range(2) == 0)
      repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(255)));
    foreach (txt[i]) begin
      maybe_ticks();
      send_req(OP_BYTE, txt[i]);
    end
    maybe_ticks();
    send_req(OP_BYTE, CHAR_CR);
  endtask

  task automatic test_random_traffic();
    int src_pct [4] = '{0, 72, 0, 7};
    int rx_pct  [4] = '{0, 0, 72, 7};
    int first;
    for (int ph = 0; ph < 4; ph++) begin
      case ($urandom_range(5))
        0:       write_period(16'd0);
        1:       write_period(16'hFFFF);
        2:       write_period(16'($urandom_range(65535)));
        default: write_period(16'($urandom_range(1, 8)));
      endcase
      src_idle_pct = src_pct[ph];
      rx_stall_pct = rx_pct[ph];
      first = req_count;
      while (req_count - first < 38) send_random_command();
      drain_replies();
    end
    src_idle_pct = 0;
    rx_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    // receiver holds off while the sender keeps offering: the queue fills
    write_period(16'd2);
    hold_req = 300;
    repeat (3) begin
      send_line("STOP");
      send_line("START");
      repeat (4) send_tick();
    end
    drain_replies();
  endtask

  initial begin
    foreach (cmd_text[i]) cmd_text[i] = 8'h00;
    text_len    = 0;
    tick_cnt    = '0;
    sec_cnt     = '0;
    tick_period = TPS_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_commands();
    test_period_extremes();
    test_multi_digit();
    test_random_traffic();
    test_backpressure();

    if (reply_q.size() != 0) report_mismatch("replies never sent", reply_q.size(), 0);
    $display("covered %0d requests, %0d reply characters checked, %0d STOP readouts",
             req_count, chars_seen, stop_replies);
    $display("%0d period settings incl. 0 and 65535, multi-digit readout, idle and stall mixes",
             period_writes);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/scsw_pkg.sv
rtl/scsw_front.sv
rtl/scsw_fifo.sv
rtl/scsw_back.sv
rtl/serial_command_stopwatch_core.sv
rtl/scsw_checker.sv
dv/tb.sv
